@@ design/pwl_pkg.sv @@
`default_nettype none
package pwl_pkg;

  localparam int DIV_W = 47;

  localparam logic [2:0] CFG_SPRING     = 3'd0;
  localparam logic [2:0] CFG_GRAVITY    = 3'd1;
  localparam logic [2:0] CFG_TIME_STEP  = 3'd2;
  localparam logic [2:0] CFG_X_UPPER    = 3'd3;
  localparam logic [2:0] CFG_Y_UPPER    = 3'd4;
  localparam logic [2:0] CFG_Z_UPPER    = 3'd5;
  localparam logic [2:0] CFG_LOWER_THR  = 3'd6;

  localparam logic OP_STEP      = 1'b0;
  localparam logic OP_HALF_KICK = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [30:0]        radius;
    logic [31:0]        mass;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } out_word_t;

  typedef struct packed {
    logic [31:0]       k;
    logic [31:0]       g;
    logic [15:0]       dt;
    logic [2:0][31:0]  upper;
    logic [31:0]       thr;
  } cfg_t;

  typedef struct packed {
    logic              opcode;
    logic [2:0][31:0]  pos;
    logic [2:0][31:0]  vel;
    logic [2:0][31:0]  fs;
    logic [2:0]        neg;
  } side_t;

  typedef struct packed {
    side_t                 side;
    logic [2:0][DIV_W-1:0] mag;
    logic [31:0]           divisor;
  } force_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/particle_wall_leapfrog_step.sv @@
`default_nettype none
// leap-frog step for one particle in a box with spring walls
// in_valid/in_ready carry one particle word (opcode, position, velocity,
// radius, mass); out_valid/out_ready carry one result word (new position,
// new velocity, force) for every accepted input word, in order
// cfg_valid/cfg_ready write one register (cfg_index, cfg_data); cfg_ready
// is always high, write only while no word is in flight
// the pipeline is 4 force stages, a 47-stage restoring divider
// (one quotient bit per stage), then 3 update stages
// throughput is one word per cycle while the output is not stalled
// when the receiver holds out_ready low with a word waiting, the whole
// pipeline holds and in_ready drops; nothing is lost or repeated
// reset clears all valid bits and loads the register defaults
module particle_wall_leapfrog_step (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pwl_pkg::in_word_t   in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output pwl_pkg::out_word_t       out_word,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);

  pwl_pkg::cfg_t   cfg;
  logic            en;
  logic            force_vld;
  pwl_pkg::force_t force_word;
  logic [2:0][pwl_pkg::DIV_W-1:0] quot;
  logic            side_vld;
  pwl_pkg::side_t  side_dly;

  assign cfg_ready = 1'b1;
  assign en        = ~out_valid | out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.k     <= 32'd65536;
      cfg.g     <= 32'hfff6_3333;
      cfg.dt    <= 16'd66;
      cfg.upper <= {32'd655360, 32'd655360, 32'd655360};
      cfg.thr   <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pwl_pkg::CFG_SPRING:    cfg.k        <= cfg_data;
        pwl_pkg::CFG_GRAVITY:   cfg.g        <= cfg_data;
        pwl_pkg::CFG_TIME_STEP: cfg.dt       <= cfg_data[15:0];
        pwl_pkg::CFG_X_UPPER:   cfg.upper[0] <= cfg_data;
        pwl_pkg::CFG_Y_UPPER:   cfg.upper[1] <= cfg_data;
        pwl_pkg::CFG_Z_UPPER:   cfg.upper[2] <= cfg_data;
        pwl_pkg::CFG_LOWER_THR: cfg.thr      <= cfg_data;
        default: ;
      endcase
    end
  end

  pwl_force u_force (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .out_valid (force_vld),
    .out_force (force_word)
  );

  for (genvar a = 0; a < 3; a++) begin : g_axis
    pwl_div #(
      .DW (pwl_pkg::DIV_W),
      .VW (32)
    ) u_div (
      .clk      (clk),
      .en       (en),
      .dividend (force_word.mag[a]),
      .divisor  (force_word.divisor),
      .quotient (quot[a])
    );
  end

  pwl_delay #(
    .DEPTH (pwl_pkg::DIV_W),
    .W     ($bits(pwl_pkg::side_t))
  ) u_delay (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (force_vld),
    .in_data   (force_word.side),
    .out_valid (side_vld),
    .out_data  (side_dly)
  );

  pwl_update u_update (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .dt        (cfg.dt),
    .in_valid  (side_vld),
    .side      (side_dly),
    .quot      (quot),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

`ifndef ASSERT_OFF
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");
  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word present right after reset");
  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(force_vld) && $stable(side_vld))
    else $error("pipeline moved during a stall");
`endif

endmodule
`default_nettype wire

@@ design/pwl_div.sv @@
`default_nettype none
module pwl_div #(
  parameter int DW = 47,
  parameter int VW = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic      [DW-1:0] quotient
);

  logic [VW-1:0] rem [DW];
  logic [DW-1:0] nq  [DW];
  logic [VW-1:0] dvs [DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [VW-1:0] prem;
    logic [DW-1:0] pnq;
    logic [VW-1:0] pdvs;
    logic [VW+1:0] diff;
    logic          ge;
    if (i == 0) begin : g_first
      assign prem = '0;
      assign pnq  = dividend;
      assign pdvs = divisor;
    end else begin : g_next
      assign prem = rem[i-1];
      assign pnq  = nq[i-1];
      assign pdvs = dvs[i-1];
    end
    assign diff = {1'b0, prem, pnq[DW-1]} - {2'b00, pdvs};
    assign ge   = ~diff[VW+1];
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? diff[VW-1:0] : {prem[VW-2:0], pnq[DW-1]};
        nq[i]  <= {pnq[DW-2:0], ge};
        dvs[i] <= pdvs;
      end
    end
  end

  assign quotient = nq[DW-1];

endmodule
`default_nettype wire

@@ design/pwl_delay.sv @@
`default_nettype none
module pwl_delay #(
  parameter int DEPTH = 47,
  parameter int W     = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire logic [W-1:0] in_data,
  output logic              out_valid,
  output logic      [W-1:0] out_data
);

  logic [DEPTH-1:0] vld;
  logic [W-1:0]     data [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
        data[i] <= data[i-1];
      end
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_data  = data[DEPTH-1];

endmodule
`default_nettype wire

@@ design/pwl_force.sv @@
`default_nettype none
module pwl_force (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire pwl_pkg::cfg_t    cfg,
  input  wire logic             in_valid,
  input  wire pwl_pkg::in_word_t in_word,
  output logic                  out_valid,
  output pwl_pkg::force_t       out_force
);

  logic [2:0][31:0] pos_in;
  logic [2:0][31:0] vel_in;
  logic [2:0][33:0] d_c;
  logic [2:0][33:0] u_c;

  logic               s1_valid;
  pwl_pkg::in_word_t  s1_item;
  logic [2:0][33:0]   s1_d;
  logic [2:0][33:0]   s1_u;

  logic               s2_valid;
  pwl_pkg::in_word_t  s2_item;
  logic [2:0][66:0]   s2_pd;
  logic [2:0][66:0]   s2_pu;
  logic [64:0]        s2_pg;

  logic               s3_valid;
  pwl_pkg::in_word_t  s3_item;
  logic [2:0][31:0]   s3_fs;
  logic [2:0][31:0]   fs_c;

  logic [2:0][48:0]   num_c;

  assign pos_in = {in_word.pos_z, in_word.pos_y, in_word.pos_x};
  assign vel_in = {in_word.vel_z, in_word.vel_y, in_word.vel_x};

  // wall overlaps, zeroed where the wall does not push
  always_comb begin
    logic signed [33:0] r34;
    logic signed [33:0] p34;
    logic signed [33:0] up34;
    logic signed [33:0] thr34;
    logic signed [33:0] d;
    logic signed [33:0] u;
    r34   = $signed({3'b000, in_word.radius});
    thr34 = 34'($signed(cfg.thr));
    for (int a = 0; a < 3; a++) begin
      p34    = 34'($signed(pos_in[a]));
      up34   = 34'($signed(cfg.upper[a]));
      d      = r34 - p34;
      u      = r34 + p34 - up34;
      d_c[a] = (d > thr34) ? d : '0;
      u_c[a] = (u > 34'sd0) ? u : '0;
    end
  end

  always_comb begin
    logic signed [52:0] f;
    for (int a = 0; a < 3; a++) begin
      f = 53'($signed(s2_pd[a]) >>> 16) - 53'($signed(s2_pu[a]) >>> 16);
      if (a == 1) begin
        f = f + 53'($signed(s2_pg) >>> 16);
      end
      fs_c[a] = pwl_pkg::sat32(64'(f));
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      num_c[a] = $signed(s3_fs[a]) * $signed({1'b0, cfg.dt});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item <= in_word;
      s1_d    <= d_c;
      s1_u    <= u_c;
      s2_item <= s1_item;
      for (int a = 0; a < 3; a++) begin
        s2_pd[a] <= $signed(s1_d[a]) * $signed({1'b0, cfg.k});
        s2_pu[a] <= $signed(s1_u[a]) * $signed({1'b0, cfg.k});
      end
      s2_pg   <= $signed(cfg.g) * $signed({1'b0, s1_item.mass});
      s3_item <= s2_item;
      s3_fs   <= fs_c;
      out_force.side.opcode <= s3_item.opcode;
      out_force.side.pos    <= {s3_item.pos_z, s3_item.pos_y, s3_item.pos_x};
      out_force.side.vel    <= {s3_item.vel_z, s3_item.vel_y, s3_item.vel_x};
      out_force.side.fs     <= s3_fs;
      for (int a = 0; a < 3; a++) begin
        out_force.side.neg[a] <= num_c[a][48];
        out_force.mag[a] <= num_c[a][48] ? 47'(-$signed(num_c[a])) : num_c[a][46:0];
      end
      out_force.divisor <= (s3_item.mass == 32'd0) ? 32'd1 : s3_item.mass;
    end
  end

  logic unused_vel;
  assign unused_vel = ^vel_in;

endmodule
`default_nettype wire

@@ design/pwl_update.sv @@
`default_nettype none
module pwl_update (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             en,
  input  wire logic [15:0]                      dt,
  input  wire logic                             in_valid,
  input  wire pwl_pkg::side_t                   side,
  input  wire logic [2:0][pwl_pkg::DIV_W-1:0]   quot,
  output logic                                  out_valid,
  output pwl_pkg::out_word_t                    out_word
);

  logic             s5_valid;
  pwl_pkg::side_t   s5_side;
  logic [2:0][31:0] s5_nv;
  logic [2:0][31:0] nv_c;

  logic             s6_valid;
  pwl_pkg::side_t   s6_side;
  logic [2:0][31:0] s6_nv;
  logic [2:0][48:0] s6_prod;

  logic [2:0][31:0] np_c;

  always_comb begin
    logic [pwl_pkg::DIV_W-1:0] qh;
    logic signed [48:0]        dv;
    logic signed [48:0]        v49;
    for (int a = 0; a < 3; a++) begin
      qh  = (side.opcode == pwl_pkg::OP_HALF_KICK) ? (quot[a] >> 1) : quot[a];
      dv  = side.neg[a] ? -$signed({2'b00, qh}) : $signed({2'b00, qh});
      v49 = 49'($signed(side.vel[a]));
      if (side.opcode == pwl_pkg::OP_HALF_KICK) begin
        nv_c[a] = pwl_pkg::sat32(64'(v49 - dv));
      end else begin
        nv_c[a] = pwl_pkg::sat32(64'(v49 + dv));
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (s6_side.opcode == pwl_pkg::OP_HALF_KICK) begin
        np_c[a] = s6_side.pos[a];
      end else begin
        np_c[a] = pwl_pkg::sat32(64'($signed(s6_side.pos[a]))
                                 + 64'($signed(s6_prod[a]) >>> 16));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s5_valid  <= in_valid;
      s6_valid  <= s5_valid;
      out_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side <= side;
      s5_nv   <= nv_c;
      s6_side <= s5_side;
      s6_nv   <= s5_nv;
      for (int a = 0; a < 3; a++) begin
        s6_prod[a] <= $signed(s5_nv[a]) * $signed({1'b0, dt});
      end
      out_word.new_pos_x <= np_c[0];
      out_word.new_pos_y <= np_c[1];
      out_word.new_pos_z <= np_c[2];
      out_word.new_vel_x <= s6_nv[0];
      out_word.new_vel_y <= s6_nv[1];
      out_word.new_vel_z <= s6_nv[2];
      out_word.force_x   <= s6_side.fs[0];
      out_word.force_y   <= s6_side.fs[1];
      out_word.force_z   <= s6_side.fs[2];
    end
  end

`ifndef ASSERT_OFF
  a_half_kick_keeps_pos: assert property (@(posedge clk) disable iff (rst)
    (en && s6_valid && s6_side.opcode == pwl_pkg::OP_HALF_KICK)
      |=> (out_word.new_pos_x == $past(s6_side.pos[0])))
    else $error("half kick moved the particle");
`endif

endmodule
`default_nettype wire
